// ===== hdl/bit_flip_mac_aes_tagger_defines.svh =====
// ---------------------------------------------------------------------------
// Bit-flip MAC tagger assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BIT_FLIP_MAC_AES_TAGGER_DEFINES_SVH
`define BIT_FLIP_MAC_AES_TAGGER_DEFINES_SVH

// Same-cycle implication
`define BFMAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFMAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfmat_pkg.sv =====
// ---------------------------------------------------------------------------
// bfmat_pkg
// Types, register map, S-box and AES round functions for the MAC tagger.
// ---------------------------------------------------------------------------
package bfmat_pkg;

  localparam int unsigned MAX_BYTES_DEF = 15;
  localparam int unsigned TAG_BYTES     = 8;
  localparam int unsigned TAG_W         = 8 * TAG_BYTES;
  localparam int unsigned MB_W          = 4;
  localparam int unsigned ADDR_W        = 6;

  // Register indexes
  localparam logic [2:0] REG_MAC_LO   = 3'd0;
  localparam logic [2:0] REG_MAC_HI   = 3'd1;
  localparam logic [2:0] REG_NONCE_LO = 3'd2;
  localparam logic [2:0] REG_NONCE_HI = 3'd3;
  localparam logic [2:0] REG_MSG_LEN  = 3'd4;

  typedef enum logic [1:0] {
    OP_REBUILD = 2'd0,
    OP_START   = 2'd1,
    OP_BYTE    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    op_e          op;
    logic [7:0]   data_byte;
    logic         is_last;
    logic [127:0] nonce;
  } item_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows; byte k sits at bits [8k+7:8k]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int unsigned src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        src = i + 4 * ((c + i) % 4);
        t[8*(i+4*c) +: 8] = SBOX[s[8*src +: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] t);
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, x;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = t[32*c +: 8];
      a1 = t[32*c+8 +: 8];
      a2 = t[32*c+16 +: 8];
      a3 = t[32*c+24 +: 8];
      x  = a0 ^ a1 ^ a2 ^ a3;
      m[32*c +: 8]    = a0 ^ x ^ xtime(a0 ^ a1);
      m[32*c+8 +: 8]  = a1 ^ x ^ xtime(a1 ^ a2);
      m[32*c+16 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      m[32*c+24 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    return m;
  endfunction

  // Next AES-128 round key from the current one
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0]  tw;
    logic [127:0] n;
    tw = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    n[31:0]   = k[31:0]   ^ tw;
    n[63:32]  = k[63:32]  ^ n[31:0];
    n[95:64]  = k[95:64]  ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

endpackage

// ===== hdl/bfmat_front.sv =====
// ---------------------------------------------------------------------------
// bfmat_front
// Takes input words, classifies the request and queues them for the back end.
// ---------------------------------------------------------------------------
module bfmat_front import bfmat_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   req_type_i,
  input  logic [7:0]   data_byte_i,
  input  logic         is_last_i,
  input  logic [63:0]  nonce_low_i,
  input  logic [63:0]  nonce_high_i,
  output logic         avail_o,
  input  logic         pop_i,
  output item_t        item_o
);

  item_t       fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q;
  logic        push;
  op_e         op;

  // Classify the request code
  always_comb begin
    unique case (req_type_i)
      2'd0:    op = OP_REBUILD;
      2'd1:    op = OP_START;
      2'd2:    op = OP_BYTE;
      default: op = OP_NONE;
    endcase
  end

  assign in_stall_o = count_q[1];
  assign push       = in_valid_i && !in_stall_o;
  assign avail_o    = count_q != 2'd0;
  assign item_o     = fifo_q[rptr_q];

  // Store queued words
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{op: op, data_byte: data_byte_i, is_last: is_last_i,
                          nonce: {nonce_high_i, nonce_low_i}};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

// ===== hdl/bfmat_aes.sv =====
// ---------------------------------------------------------------------------
// bfmat_aes
// Iterative AES-128 encryptor, one round per cycle, key expanded on the fly.
// ---------------------------------------------------------------------------
module bfmat_aes import bfmat_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [127:0]   key_i,
  input  logic [127:0]   block_i,
  output logic           done_o,
  output logic [127:0]   result_o
);

  logic         busy_q, done_q;
  logic [3:0]   round_q;
  logic [127:0] st_q, rk_q;
  logic [7:0]   rc_q;
  logic [127:0] rk_n, ss;

  assign rk_n     = key_next(rk_q, rc_q);
  assign ss       = sub_shift(st_q);
  assign done_o   = done_q;
  assign result_o = st_q;

  // Datapath: load whitened block, then run rounds
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st_q <= block_i ^ key_i;
      rk_q <= key_i;
      rc_q <= 8'h01;
    end else if (busy_q) begin
      st_q <= ((round_q == 4'd10) ? ss : mix_cols(ss)) ^ rk_n;
      rk_q <= rk_n;
      rc_q <= xtime(rc_q);
    end
  end

  // Round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= 4'd0;
    end else begin
      done_q <= busy_q && (round_q == 4'd10);
      if (start_i) begin
        busy_q  <= 1'b1;
        round_q <= 4'd1;
      end else if (busy_q) begin
        if (round_q == 4'd10) busy_q <= 1'b0;
        round_q <= round_q + 4'd1;
      end
    end
  end

endmodule

// ===== hdl/bfmat_back.sv =====
// ---------------------------------------------------------------------------
// bfmat_back
// Executes queued requests: table rebuild, nonce masking and bit walks.
// ---------------------------------------------------------------------------
module bfmat_back import bfmat_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [127:0]     mac_key_i,
  input  logic [127:0]     nonce_key_i,
  input  logic [MB_W-1:0]  message_bytes_i,
  input  logic             avail_i,
  output logic             pop_o,
  input  item_t            item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [TAG_W-1:0] tag_o,
  output logic             overflow_o
);

  localparam int unsigned DEPTH = MAX_BYTES * 8 + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RB0   = 3'd1;
  localparam logic [2:0] S_RB1   = 3'd2;
  localparam logic [2:0] S_NONCE = 3'd3;
  localparam logic [2:0] S_MSG   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  item_t            item_q, item_d;
  logic [AW-1:0]    idx_q, idx_d, tbits_q, tbits_d, pos_q, pos_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [TAG_W-1:0] base_q, base_d, run_q, run_d, e0_q, e0_d;
  logic             ovf_q, ovf_d, cv_q, cv_d, apply_q, apply_d;
  logic [127:0]     cnon_q, cnon_d, cc_q, cc_d;
  logic             out_valid_q, out_valid_d, out_ovf_q, out_ovf_d;
  logic [TAG_W-1:0] out_tag_q, out_tag_d;

  logic             aes_go, aes_done, aes_nkey;
  logic [127:0]     aes_blk, aes_out;
  logic             mem_we;
  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rdata_q;
  logic [127:0]     cleared, cur_nonce;
  logic [MB_W-1:0]  nb;
  logic             out_free;

  bfmat_aes u_aes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (aes_go),
    .key_i    (aes_nkey ? nonce_key_i : mac_key_i),
    .block_i  (aes_blk),
    .done_o   (aes_done),
    .result_o (aes_out)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cur_nonce = (state_q == S_IDLE) ? item_i.nonce : item_q.nonce;
  assign cleared   = {cur_nonce[127:1], 1'b0};

  // Clamp the table length
  always_comb begin
    if (message_bytes_i == '0) nb = MB_W'(1);
    else if (message_bytes_i > MB_W'(MAX_BYTES)) nb = MB_W'(MAX_BYTES);
    else nb = message_bytes_i;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    tbits_d     = tbits_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    run_d       = run_q;
    e0_d        = e0_q;
    ovf_d       = ovf_q;
    cv_d        = cv_q;
    cnon_d      = cnon_q;
    cc_d        = cc_q;
    apply_d     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_tag_d   = out_tag_q;
    out_ovf_d   = out_ovf_q;
    pop_o       = 1'b0;
    aes_go      = 1'b0;
    aes_nkey    = 1'b0;
    aes_blk     = '0;
    mem_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (avail_i) begin
          pop_o  = 1'b1;
          item_d = item_i;
          unique case (item_i.op)
            OP_REBUILD: begin
              tbits_d = AW'({nb, 3'b000});
              idx_d   = '0;
              base_d  = '0;
              aes_go  = 1'b1;
              state_d = S_RB0;
            end
            OP_START: begin
              if (!cv_q || cleared != cnon_q) begin
                aes_go   = 1'b1;
                aes_nkey = 1'b1;
                aes_blk  = cleared;
                state_d  = S_NONCE;
              end else begin
                run_d   = base_q ^ (item_i.nonce[0] ? cc_q[127:64] : cc_q[63:0]);
                pos_d   = '0;
                ovf_d   = 1'b0;
                state_d = S_DONE;
              end
            end
            OP_BYTE: begin
              cnt_d   = '0;
              state_d = S_MSG;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RB0: begin
        if (aes_done) begin
          e0_d          = aes_out[TAG_W-1:0];
          aes_go        = 1'b1;
          aes_blk[7:0]  = 8'({idx_q, 1'b1});
          state_d       = S_RB1;
        end
      end
      S_RB1: begin
        if (aes_done) begin
          mem_we = 1'b1;
          base_d = base_q ^ e0_q;
          if (idx_q == tbits_q) begin
            cv_d    = 1'b0;
            cnon_d  = '0;
            cc_d    = '0;
            ovf_d   = 1'b0;
            run_d   = base_q ^ e0_q;
            pos_d   = '0;
            state_d = S_DONE;
          end else begin
            idx_d        = idx_q + AW'(1);
            aes_go       = 1'b1;
            aes_blk[7:0] = 8'({idx_q + AW'(1), 1'b0});
            state_d      = S_RB0;
          end
        end
      end
      S_NONCE: begin
        if (aes_done) begin
          cc_d    = aes_out;
          cnon_d  = cleared;
          cv_d    = 1'b1;
          run_d   = base_q ^ (item_q.nonce[0] ? aes_out[127:64] : aes_out[63:0]);
          pos_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_MSG: begin
        // Apply the entry read in the previous cycle
        if (apply_q) run_d = run_q ^ rdata_q;
        if (cnt_q < 4'd8) begin
          if (pos_q >= tbits_q) begin
            ovf_d = 1'b1;
          end else begin
            apply_d = item_q.data_byte[3'd7 - cnt_q[2:0]];
            pos_d   = pos_q + AW'(1);
          end
        end else if (cnt_q == 4'd8) begin
          apply_d = item_q.is_last;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd9) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_tag_d   = run_q;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Bit tag table
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx_q] <= e0_q ^ aes_out[TAG_W-1:0];
    rdata_q <= mem[pos_q];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_d_hold: begin
      item_q    <= item_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      e0_q      <= e0_d;
      out_tag_q <= out_tag_d;
      out_ovf_q <= out_ovf_d;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tbits_q     <= '0;
      pos_q       <= '0;
      base_q      <= '0;
      run_q       <= '0;
      ovf_q       <= 1'b0;
      cv_q        <= 1'b0;
      cnon_q      <= '0;
      cc_q        <= '0;
      apply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tbits_q     <= tbits_d;
      pos_q       <= pos_d;
      base_q      <= base_d;
      run_q       <= run_d;
      ovf_q       <= ovf_d;
      cv_q        <= cv_d;
      cnon_q      <= cnon_d;
      cc_q        <= cc_d;
      apply_q     <= apply_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_o       = out_tag_q;
  assign overflow_o  = out_ovf_q;

endmodule

// ===== hdl/bit_flip_mac_aes_tagger.sv =====
// ---------------------------------------------------------------------------
// bit_flip_mac_aes_tagger
// Bit-flip MAC with AES-128 bit tags and nonce masking, 64-bit running tag.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | req_type, data_byte, is_last, nonce
//  out     | output    | out_valid_o/out_stall_i | tag, overflow
//  cfg     | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// Message byte: pop, eight table reads, padding read, last apply, result.
// Start: a cache hit needs no AES block; a miss runs one AES block at a round a cycle.
// Rebuild: two AES blocks per table entry, 8*len+1 entries.
// Reset clears all control state; the bit tag table is not cleared.
// A two-word queue keeps input words flowing while a result waits on out_stall_i.
module bit_flip_mac_aes_tagger import bfmat_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic              is_last_i,
  input  logic [63:0]       nonce_low_i,
  input  logic [63:0]       nonce_high_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TAG_W-1:0]  tag_o,
  output logic              overflow_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0]     mac_lo_q, mac_hi_q, nk_lo_q, nk_hi_q;
  logic [MB_W-1:0] mb_q;
  logic [2:0]      reg_idx;
  logic            wr_en, avail, pop;
  item_t           item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_lo_q <= '0;
      mac_hi_q <= '0;
      nk_lo_q  <= '0;
      nk_hi_q  <= '0;
      mb_q     <= MB_W'(15);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAC_LO:   mac_lo_q <= pwdata;
        REG_MAC_HI:   mac_hi_q <= pwdata;
        REG_NONCE_LO: nk_lo_q  <= pwdata;
        REG_NONCE_HI: nk_hi_q  <= pwdata;
        REG_MSG_LEN:  mb_q     <= pwdata[MB_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (reg_idx)
      REG_MAC_LO:   prdata = mac_lo_q;
      REG_MAC_HI:   prdata = mac_hi_q;
      REG_NONCE_LO: prdata = nk_lo_q;
      REG_NONCE_HI: prdata = nk_hi_q;
      REG_MSG_LEN:  prdata = 64'(mb_q);
      default:      prdata = '0;
    endcase
  end

  bfmat_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .is_last_i    (is_last_i),
    .nonce_low_i  (nonce_low_i),
    .nonce_high_i (nonce_high_i),
    .avail_o      (avail),
    .pop_i        (pop),
    .item_o       (item)
  );

  bfmat_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mac_key_i       ({mac_hi_q, mac_lo_q}),
    .nonce_key_i     ({nk_hi_q, nk_lo_q}),
    .message_bytes_i (mb_q),
    .avail_i         (avail),
    .pop_o           (pop),
    .item_i          (item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tag_o           (tag_o),
    .overflow_o      (overflow_o)
  );

endmodule

// ===== hdl/bfmat_checker.sv =====
// ---------------------------------------------------------------------------
// bfmat_checker
// Port-level checks on the tagger, bound to the top level.
// ---------------------------------------------------------------------------
`include "bit_flip_mac_aes_tagger_defines.svh"

module bfmat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] tag_o,
  input logic        overflow_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [5:0]  paddr,
  input logic [63:0] prdata
);

  `BFMAT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `BFMAT_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(tag_o) && $stable(overflow_o), "stalled result changed")
  `BFMAT_ASSERT_NOW(a_full_by_push, in_stall_o && !$past(in_stall_o), $past(in_valid_i && !in_stall_o), "queue filled without a word")
  `BFMAT_ASSERT_NOW(a_len_width, psel && penable && !pwrite && paddr == 6'd32, prdata[63:4] == 60'd0, "length register reads wide")

endmodule

bind bit_flip_mac_aes_tagger bfmat_checker u_bfmat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .tag_o       (tag_o),
  .overflow_o  (overflow_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .prdata      (prdata)
);

// ===== tb/bit_flip_mac_aes_tagger_test.sv =====
// ---------------------------------------------------------------------------
// Bit-flip MAC tagger testbench
// Drives rebuild, start and message-byte words through the valid/stall input
// channel and checks every tag and overflow result against a local AES-based
// predictor. The sender runs in bursts with gaps and the receiver stalls on a
// pattern of its own, with one long hold-off. The registers are rewritten
// between phases over the APB port.
// ---------------------------------------------------------------------------
module bit_flip_mac_aes_tagger_test;
  import bfmat_pkg::*;

  localparam int unsigned DEPTH = 121;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  typedef struct {
    op_e         op;
    logic [7:0]  data;
    logic        last;
    logic [63:0] nlo;
    logic [63:0] nhi;
    logic        chk;
    logic [63:0] etag;
    logic        eovf;
  } stim_t;

  typedef struct {
    logic [63:0] tag;
    logic        ovf;
  } tag_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [7:0] data_byte_i = '0;
  logic is_last_i = 1'b0;
  logic [63:0] nonce_low_i = '0;
  logic [63:0] nonce_high_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [TAG_W-1:0] tag_o;
  logic overflow_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  bit_flip_mac_aes_tagger dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  logic [63:0] mk_lo, mk_hi, nk_lo, nk_hi;
  logic [3:0] msg_len;
  logic [63:0] bit_tags [DEPTH];
  logic [63:0] base_tag, run_tag;
  int unsigned bit_pos, table_bits;
  logic [127:0] nonce_seen, nonce_ct;
  logic nonce_hit_ok, ovf_flag;

  tag_word_t expected_tags [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned long_hold = 0;
  bit stim_done = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [7:0] sb(input logic [7:0] x);
    logic [7:0] t [0:255];
    t = SBOX;
    return t[x];
  endfunction

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-128 encrypt, byte k of each vector at bits [8k+7:8k]
  function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] rc, t0, t1, t2, t3, sv, a0, a1, a2, a3, x;
    logic [127:0] o;
    rc = 8'h01;
    for (int k = 0; k < 16; k++) rk[k] = key[8*k +: 8];
    for (int i = 16; i < 176; i += 4) begin
      t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
      if ((i % 16) == 0) begin
        sv = t0;
        t0 = sb(t1) ^ rc; t1 = sb(t2); t2 = sb(t3); t3 = sb(sv);
        rc = mul2(rc);
      end
      rk[i] = rk[i-16] ^ t0; rk[i+1] = rk[i-15] ^ t1;
      rk[i+2] = rk[i-14] ^ t2; rk[i+3] = rk[i-13] ^ t3;
    end
    for (int k = 0; k < 16; k++) s[k] = pt[8*k +: 8] ^ rk[k];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = sb(s[i + 4*((c+i) % 4)]);
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          t[4*c] = a0 ^ x ^ mul2(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ mul2(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ mul2(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ mul2(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) s[k] = t[k] ^ rk[16*r+k];
    end
    for (int k = 0; k < 16; k++) o[8*k +: 8] = s[k];
    return o;
  endfunction

  // Compute the tag and overflow flag that one request word leaves behind
  task automatic predict_tag(input stim_t w);
    logic [127:0] e0, e1, nc;
    int unsigned nb;
    case (w.op)
      OP_REBUILD: begin
        nb = (msg_len == 0) ? 1 : msg_len;
        table_bits = nb * 8;
        base_tag = '0;
        for (int i = 0; i <= table_bits; i++) begin
          e0 = aes128({mk_hi, mk_lo}, {120'd0, 8'(2*i)});
          e1 = aes128({mk_hi, mk_lo}, {120'd0, 8'(2*i+1)});
          base_tag ^= e0[63:0];
          bit_tags[i] = e0[63:0] ^ e1[63:0];
        end
        nonce_seen = '0; nonce_ct = '0; nonce_hit_ok = 1'b0; ovf_flag = 1'b0;
        run_tag = base_tag; bit_pos = 0;
      end
      OP_START: begin
        nc = {w.nhi, w.nlo[63:1], 1'b0};
        if (!nonce_hit_ok || nc != nonce_seen) begin
          nonce_ct = aes128({nk_hi, nk_lo}, nc);
          nonce_seen = nc;
          nonce_hit_ok = 1'b1;
        end
        run_tag = base_tag ^ (w.nlo[0] ? nonce_ct[127:64] : nonce_ct[63:0]);
        bit_pos = 0; ovf_flag = 1'b0;
      end
      OP_BYTE: begin
        for (int j = 0; j < 8; j++) begin
          if (bit_pos >= table_bits || bit_pos >= DEPTH - 1) ovf_flag = 1'b1;
          else begin
            if (w.data[7-j]) run_tag ^= bit_tags[bit_pos];
            bit_pos++;
          end
        end
        if (w.last && bit_pos < DEPTH) run_tag ^= bit_tags[bit_pos];
      end
      default: ;
    endcase
  endtask

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MAC_LO: mk_lo = val;
      REG_MAC_HI: mk_hi = val;
      REG_NONCE_LO: nk_lo = val;
      REG_NONCE_HI: nk_hi = val;
      REG_MSG_LEN: msg_len = val[3:0];
      default: ;
    endcase
  endtask

  // Send one word, after a random gap when gap is set, then record what it should produce
  task automatic send_word(input stim_t w, input bit gap);
    int unsigned g;
    if (gap) begin
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (g != 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    req_type_i <= w.op; data_byte_i <= w.data; is_last_i <= w.last;
    nonce_low_i <= w.nlo; nonce_high_i <= w.nhi;
    do @(posedge clk_i); while (in_stall_o);
    predict_tag(w);
    if (w.chk && (w.etag !== run_tag || w.eovf !== ovf_flag))
      report("table row", run_tag, w.etag);
    expected_tags.push_back('{tag: run_tag, ovf: ovf_flag});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic stim_t mk(op_e op, logic [7:0] d, logic l, logic [63:0] lo,
                               logic [63:0] hi);
    return '{op: op, data: d, last: l, nlo: lo, nhi: hi, chk: 1'b0, etag: '0, eovf: 1'b0};
  endfunction

  function automatic stim_t rand_word(int unsigned bias);
    stim_t w;
    int unsigned r;
    w = mk(OP_BYTE, 8'($urandom), 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < bias) w.op = OP_START;
    else if (r < bias + 2) w.op = OP_NONE;
    else if (r < bias + 3) w.op = OP_REBUILD;
    if ($urandom_range(0, 4) == 0) w.nhi = 64'hfeed_0000_0000_0001;
    if ($urandom_range(0, 2) == 0) w.nlo = {63'h1234_5678, w.nlo[0]};
    w.last = ($urandom_range(0, 5) == 0);
    return w;
  endfunction

  // Directed table: rows with chk set carry their expected result
  stim_t dir_rows [$];

  initial begin
    stim_t w;
    int unsigned n, msg;
    mk_lo = '0; mk_hi = '0; nk_lo = '0; nk_hi = '0; msg_len = 4'd15;
    base_tag = '0; run_tag = '0; bit_pos = 0; table_bits = 0;
    nonce_seen = '0; nonce_ct = '0; nonce_hit_ok = 1'b0; ovf_flag = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: the idle code reports zero, then build a short table
    w = mk(OP_NONE, 8'hff, 1'b1, '1, '1); w.chk = 1'b1;
    dir_rows.push_back(w);
    reg_write(REG_MSG_LEN, 64'd1);
    foreach (dir_rows[i]) send_word(dir_rows[i], 1'b0);
    dir_rows.delete();
    dir_rows.push_back(mk(OP_REBUILD, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_START, 0, 0, 64'h0, 64'h0));
    dir_rows.push_back(mk(OP_START, 0, 0, 64'h1, 64'h0));
    dir_rows.push_back(mk(OP_START, 0, 0, '1, '1));
    dir_rows.push_back(mk(OP_START, 0, 0, 64'hffff_ffff_ffff_fffe, '1));
    dir_rows.push_back(mk(OP_BYTE, 8'hff, 0, 0, 0));
    dir_rows.push_back(mk(OP_BYTE, 8'h80, 1, 0, 0));
    dir_rows.push_back(mk(OP_BYTE, 8'h01, 1, 0, 0));
    dir_rows.push_back(mk(OP_START, 0, 0, 64'h5, 64'h9));
    dir_rows.push_back(mk(OP_BYTE, 8'h00, 1, 0, 0));
    dir_rows.push_back(mk(OP_BYTE, 8'h00, 1, 0, 0));
    dir_rows.push_back(mk(OP_NONE, 8'h55, 1, '1, '1));
    foreach (dir_rows[i]) send_word(dir_rows[i], 1'b0);
    dir_rows.delete();
    drain();

    // Full-length table under all-ones keys
    reg_write(REG_MAC_LO, '1); reg_write(REG_MAC_HI, '1);
    reg_write(REG_NONCE_LO, '1); reg_write(REG_NONCE_HI, '1);
    reg_write(REG_MSG_LEN, 64'd15);
    send_word(mk(OP_REBUILD, 0, 0, 0, 0), 1'b0);
    send_word(mk(OP_START, 0, 0, 64'hdead_beef, 64'h1), 1'b0);
    for (int i = 0; i < 16; i++) send_word(mk(OP_BYTE, 8'(i * 17), i == 15, 0, 0), 1'b0);
    drain();

    // Random phases over several settings; length 0 clamps to one byte
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_MAC_LO, {$urandom, $urandom}); reg_write(REG_MAC_HI, {$urandom, $urandom});
      reg_write(REG_NONCE_LO, {$urandom, $urandom});
      reg_write(REG_NONCE_HI, {$urandom, $urandom});
      msg = (ph == 0) ? 0 : (ph == 5) ? 15 : $urandom_range(1, 4);
      reg_write(REG_MSG_LEN, 64'(msg));
      send_word(mk(OP_REBUILD, 0, 0, 0, 0), 1'b1);
      n = 0;
      while (n < 250) begin
        // Well-formed message: start, bytes, last byte
        send_word(mk(OP_START, 0, 0, {$urandom, $urandom}, ($urandom_range(0, 1) ?
                  64'hfeed_0000_0000_0001 : {$urandom, $urandom})), 1'b1);
        n++;
        for (int b = $urandom_range(0, (msg == 0 ? 1 : msg) + 1); b >= 0; b--) begin
          send_word(mk(OP_BYTE, 8'($urandom), b == 0, 0, 0), 1'b1);
          n++;
        end
        if ($urandom_range(0, 4) == 0) begin
          w = rand_word(20);
          if (w.op == OP_REBUILD && msg == 15) w.op = OP_NONE;
          send_word(w, 1'b1);
          n++;
        end
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // Receiver stall pattern, with one long hold-off early on
  always @(posedge clk_i) begin
    if (long_hold == 0 && $realtime > 4000 && $realtime < 4100) long_hold <= 300;
    else if (long_hold > 1) long_hold <= long_hold - 1;
    out_stall_i <= (long_hold > 1) ||
                   ((($time / 20) % 64) < 32 && $urandom_range(0, 2) == 0);
  end

  // Compare accepted results and watch for a hang
  always @(posedge clk_i) begin
    tag_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tags.size() == 0) begin
        report("unexpected word", tag_o, '0);
      end else begin
        e = expected_tags.pop_front();
        if (tag_o !== e.tag) report("tag", tag_o, e.tag);
        if (overflow_o !== e.ovf) report("overflow", 64'(overflow_o), 64'(e.ovf));
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done || idle_cycles >= WATCHDOG_LIMIT);
    if (!stim_done) begin
      $display("bit_flip_mac_aes_tagger_test NOT OK");
    end else if (errors == 0 && expected_tags.size() == 0) begin
      $display("bit_flip_mac_aes_tagger_test OK");
    end else begin
      $display("bit_flip_mac_aes_tagger_test NOT OK");
    end
    $finish;
  end

endmodule
